[rtl/core/xlab_pkg.sv]
// Package for the XYZ to CIELAB pipeline: fixed-point formats, constants,
// configuration register indexes and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xlab_pkg;

  // Input and register formats
  localparam int InFracBits = 16;
  localparam int InW        = InFracBits + 1;
  localparam int RegW       = 18;
  localparam int ProdW      = InW + RegW;

  // Ratio kept exactly at scale 2^-RatioShift, saturated at 2.0
  localparam int RatioShift = 16 + InFracBits;
  localparam int RatioW     = RatioShift + 2;
  localparam logic [ProdW-1:0] RatioCap = ProdW'(64'd2 << RatioShift);

  // Transfer output f in Q.FBits, found one bit per stage
  localparam int FBits      = 20;
  localparam int FW         = FBits + 1;
  localparam int RootStages = FW;
  localparam int CubeShift  = 3 * FBits - RatioShift;

  // Linear segment: f = (24389*p + 432) / 3132, at the ratio scale
  localparam logic [RatioW-1:0] LinMax =
    RatioW'((64'd216 << RatioShift) / 64'd24389);
  localparam logic [63:0] LinBias = 64'd432 << RatioShift;
  localparam logic [63:0] LinDiv  = 64'd3132 << (RatioShift - FBits);

  // Output widths
  localparam int LW  = 14;
  localparam int AW  = 17;
  localparam int BW  = 15;
  localparam int MulW = 40;

  // Configuration
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CfgInvX = 2'd0,
    CfgInvY = 2'd1,
    CfgInvZ = 2'd2,
    CfgNone = 2'd3
  } cfg_reg_e;

  localparam logic [RegW-1:0] InvXReset = 18'd68951;
  localparam logic [RegW-1:0] InvYReset = 18'd65536;
  localparam logic [RegW-1:0] InvZReset = 18'd60189;

  // One stage of the root / quotient search
  typedef struct packed {
    logic              lin;
    logic [63:0]       tgt;
    logic [FW-1:0]     r;
    logic [2*FW-1:0]   r2;
    logic [63:0]       r3;
  } root_stage_t;

endpackage

`default_nettype wire

[rtl/core/xlab_in_if.sv]
// Input channel: one XYZ colour per item, valid/ready handshake.
// Depends on xlab_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface xlab_in_if;
  logic                     valid;
  logic                     ready;
  logic [xlab_pkg::InW-1:0] x_in;
  logic [xlab_pkg::InW-1:0] y_in;
  logic [xlab_pkg::InW-1:0] z_in;

  modport source (output valid, output x_in, output y_in, output z_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

`default_nettype wire

[rtl/core/xlab_out_if.sv]
// Output channel: one CIELAB colour per item, valid/ready handshake.
// Depends on xlab_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface xlab_out_if;
  logic                           valid;
  logic                           ready;
  logic        [xlab_pkg::LW-1:0] lightness;
  logic signed [xlab_pkg::AW-1:0] green_red;
  logic signed [xlab_pkg::BW-1:0] blue_yellow;

  modport source (output valid, output lightness, output green_red, output blue_yellow,
                  input ready);
  modport sink   (input valid, input lightness, input green_red, input blue_yellow,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/xlab_curve.sv]
// One channel: scale by the white reciprocal, saturate, then the CIE
// transfer as a bit-per-stage cube root or restoring divide. Uses xlab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xlab_curve (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [xlab_pkg::InW-1:0]      val_i,
  input  wire logic [xlab_pkg::RegW-1:0]     inv_i,
  output      logic [xlab_pkg::FW-1:0]       f_o
);

  logic [xlab_pkg::ProdW-1:0]  prod_q;
  logic [xlab_pkg::RatioW-1:0] sat;
  xlab_pkg::root_stage_t       head_d;
  xlab_pkg::root_stage_t       st_q [xlab_pkg::RootStages+1];
  xlab_pkg::root_stage_t       st_d [xlab_pkg::RootStages+1];

  // Stage 1: exact product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= xlab_pkg::ProdW'(val_i) * xlab_pkg::ProdW'(inv_i);
    end
  end

  // Stage 2: saturate, pick the segment and load the search target
  always_comb begin
    sat = (prod_q > xlab_pkg::RatioCap) ? xlab_pkg::RatioW'(xlab_pkg::RatioCap)
                                        : prod_q[xlab_pkg::RatioW-1:0];
    head_d     = '0;
    head_d.lin = (sat <= xlab_pkg::LinMax);
    if (head_d.lin) begin
      head_d.tgt = 64'(sat) * 64'd24389 + xlab_pkg::LinBias;
    end else begin
      head_d.tgt = 64'(sat) << xlab_pkg::CubeShift;
    end
  end

  assign st_d[0] = head_d;

  // Search stages, most significant bit first
  for (genvar j = 0; j < xlab_pkg::RootStages; j++) begin : g_stage
    localparam int B = xlab_pkg::FBits - j;
    logic [63:0] r64, c3, c2, den;
    always_comb begin
      r64 = 64'(st_q[j].r);
      c3  = st_q[j].r3 + ((64'(st_q[j].r2) * 64'd3) << B)
            + ((r64 * 64'd3) << (2 * B)) + (64'd1 << (3 * B));
      c2  = 64'(st_q[j].r2) + (r64 << (B + 1)) + (64'd1 << (2 * B));
      den = xlab_pkg::LinDiv << B;
      st_d[j+1] = st_q[j];
      if (st_q[j].lin) begin
        if (st_q[j].tgt >= den) begin
          st_d[j+1].tgt  = st_q[j].tgt - den;
          st_d[j+1].r[B] = 1'b1;
        end
      end else if (c3 <= st_q[j].tgt) begin
        st_d[j+1].r3   = c3;
        st_d[j+1].r2   = c2[2*xlab_pkg::FW-1:0];
        st_d[j+1].r[B] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k <= xlab_pkg::RootStages; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign f_o = st_q[xlab_pkg::RootStages].r;

endmodule

`default_nettype wire

[rtl/core/xyz_to_cielab.sv]
// Top level: XYZ to CIELAB stream conversion with white-point registers.
// Depends on xlab_pkg, xlab_in_if, xlab_out_if and xlab_curve.
//
//   port    dir  item
//   pix_i   in   x_in, y_in, z_in (unsigned Q1.16)
//   lab_o   out  lightness, green_red, blue_yellow (units of 1/64)
//   cfg_*   in   white reciprocals, Q2.16, write only
//
// One item per cycle while lab_o does not stall; stages: product, saturate, 21 root stages,
// scale, round. The 21-stage cube root / divide search sets the depth.
// Reset restores the D65 reciprocals and empties the pipeline.
// A stall on lab_o freezes every stage; pix_i.ready drops with it.
`timescale 1ns / 1ps
`default_nettype none

module xyz_to_cielab (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  xlab_in_if.sink                            pix_i,
  xlab_out_if.source                         lab_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [xlab_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [xlab_pkg::RegW-1:0]     cfg_wdata_i
);

  localparam int Depth = xlab_pkg::RootStages + 4;

  logic [xlab_pkg::RegW-1:0] inv_x_q, inv_y_q, inv_z_q;
  logic [Depth-1:0]          vld_q;
  logic                      en;
  logic [xlab_pkg::FW-1:0]   fx, fy, fz;
  logic signed [xlab_pkg::MulW-1:0] ml_q, ma_q, mb_q;
  logic signed [xlab_pkg::MulW-1:0] rl, ra, rb;
  logic [xlab_pkg::LW-1:0]   l_q;
  logic signed [xlab_pkg::AW-1:0] a_q;
  logic signed [xlab_pkg::BW-1:0] b_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= xlab_pkg::InvXReset;
      inv_y_q <= xlab_pkg::InvYReset;
      inv_z_q <= xlab_pkg::InvZReset;
    end else if (cfg_we_i) begin
      unique case (xlab_pkg::cfg_reg_e'(cfg_idx_i))
        xlab_pkg::CfgInvX: inv_x_q <= cfg_wdata_i;
        xlab_pkg::CfgInvY: inv_y_q <= cfg_wdata_i;
        xlab_pkg::CfgInvZ: inv_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: the output register frees up or is empty
  assign en          = !vld_q[Depth-1] || lab_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], pix_i.valid};
    end
  end

  // Channel transfers
  xlab_curve u_curve_x (.clk_i, .en_i(en), .val_i(pix_i.x_in), .inv_i(inv_x_q),
                        .f_o(fx));
  xlab_curve u_curve_y (.clk_i, .en_i(en), .val_i(pix_i.y_in), .inv_i(inv_y_q),
                        .f_o(fy));
  xlab_curve u_curve_z (.clk_i, .en_i(en), .val_i(pix_i.z_in), .inv_i(inv_z_q),
                        .f_o(fz));

  // Scale stage: L, a, b in Q.20 at 1/64 units
  always_ff @(posedge clk_i) begin
    if (en) begin
      ml_q <= xlab_pkg::MulW'(signed'({1'b0, fy})) * 40'sd7424 - (40'sd1024 <<< 20);
      ma_q <= (xlab_pkg::MulW'(signed'({1'b0, fx})) - xlab_pkg::MulW'(signed'({1'b0, fy})))
              * 40'sd32000;
      mb_q <= (xlab_pkg::MulW'(signed'({1'b0, fy})) - xlab_pkg::MulW'(signed'({1'b0, fz})))
              * 40'sd12800;
    end
  end

  // Round to nearest, ties upward
  assign rl = (ml_q + 40'sd524288) >>> xlab_pkg::FBits;
  assign ra = (ma_q + 40'sd524288) >>> xlab_pkg::FBits;
  assign rb = (mb_q + 40'sd524288) >>> xlab_pkg::FBits;

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q <= rl[xlab_pkg::MulW-1] ? '0 : rl[xlab_pkg::LW-1:0];
      a_q <= ra[xlab_pkg::AW-1:0];
      b_q <= rb[xlab_pkg::BW-1:0];
    end
  end

  assign lab_o.valid       = vld_q[Depth-1];
  assign lab_o.lightness   = l_q;
  assign lab_o.green_red   = a_q;
  assign lab_o.blue_yellow = b_q;

  // An accepted item enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> vld_q[0])
    else $error("accepted item not in pipeline");

  // A stall freezes all valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // Lightness stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lab_o.valid |-> lab_o.lightness <= 14'd8400)
    else $error("lightness out of range");

endmodule

`default_nettype wire
